@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge
`define ASSERT_AT(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// property checked at every rising clock edge outside reset
`define ASSERT_AT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

@@ hw/rtl/pod_pkg.sv @@
// shared constants, payload types and sequencer states of the pattern delimiter
package pod_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int CNT_W = $clog2(PATTERN_MAX + 1);
  localparam int LEN_W = 5;
  localparam int PAT_REG_BYTES = 16;
  localparam int PAT_SEL_W = 4;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_SHIFT = 3;
  localparam int REG_IDX_W = CFG_ADDR_W - REG_SHIFT;

  localparam logic [REG_IDX_W-1:0] REG_LEN  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_LOW  = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_HIGH = REG_IDX_W'(2);

  localparam logic [7:0] DELIM_BYTE = 8'h5F;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_TAKE,
    ST_BYTE,
    ST_FLUSH,
    ST_CLOSE
  } seq_state_t;

endpackage

@@ hw/rtl/pod_cell.sv @@
// one window cell: holds a text byte, compares its incoming byte with its pattern byte
module pod_cell (
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] byte_in,
  input  logic [7:0] pat_byte,
  output logic [7:0] byte_q,
  output logic       match
);

  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_q = byte_r;
  assign match  = (byte_in == pat_byte);

endmodule

@@ hw/rtl/pod_outq.sv @@
// two-entry result queue between the sequencer and the output channel
module pod_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  pod_pkg::out_item_t  push_item,
  output logic                can_push,
  output logic                out_valid,
  input  logic                out_ready,
  output pod_pkg::out_item_t  out_item
);

  pod_pkg::out_item_t e0_r, e0_nxt;
  pod_pkg::out_item_t e1_r, e1_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic               pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_item  = e0_r;
  assign can_push  = (cnt_r != 2'd2);

  always_comb begin
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    cnt_nxt = cnt_r;
    priority if (pop && push_valid) begin
      if (cnt_r == 2'd1) begin
        e0_nxt = push_item;
      end else begin
        e0_nxt = e1_r;
        e1_nxt = push_item;
      end
    end else if (pop) begin
      e0_nxt  = e1_r;
      cnt_nxt = cnt_r - 2'd1;
    end else if (push_valid) begin
      if (cnt_r == 2'd0) begin
        e0_nxt = push_item;
      end else begin
        e1_nxt = push_item;
      end
      cnt_nxt = cnt_r + 2'd1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ hw/rtl/pattern_occurrence_delimiter.sv @@
// top level: window cell chain, region sequencer, result queue and register port
// a released byte enters the output queue when its request is taken, a byte after a delimiter from the byte state
// throughput: one request per cycle while no delimiter is due and the queue has room; a delimiter stalls input
// end of text: held bytes are flushed with their delimiters, then a closing underscore if a region is open
// the sequencer produces one result per cycle into a two-entry output queue while the queue has room
// reset: synchronous rst_n clears text state and queue, length to 1, pattern bytes to 0
module pattern_occurrence_delimiter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  pod_pkg::in_item_t                    in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output pod_pkg::out_item_t                   out_item,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pod_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [pod_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [pod_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  localparam int NCELL = pod_pkg::PATTERN_MAX;
  localparam int CW    = pod_pkg::CNT_W;
  localparam int IW    = pod_pkg::IDX_W;

  // register port
  logic [pod_pkg::LEN_W-1:0]        len_raw_r;
  logic [63:0]                      pat_low_r;
  logic [63:0]                      pat_high_r;
  logic                             cfg_wr;
  logic [pod_pkg::REG_IDX_W-1:0]    cfg_idx;
  logic                             cfg_len_wr;

  // cell chain
  logic [NCELL-1:0][7:0]            cell_in;
  logic [NCELL-1:0][7:0]            cell_q;
  logic [NCELL-1:0][7:0]            cell_pat;
  logic [NCELL-1:0]                 cell_match;
  logic [NCELL-1:0]                 beyond;
  logic [pod_pkg::PAT_REG_BYTES-1:0][7:0] pat_arr;

  // sequencer
  pod_pkg::seq_state_t              st_r, st_nxt, end_state;
  logic [CW-1:0]                    fill_r, fill_nxt;
  logic [CW-1:0]                    cover_r, cover_nxt;
  logic                             inside_r, inside_nxt;
  logic [7:0]                       held_byte_r, held_byte_nxt;
  logic                             held_last_r, held_last_nxt;

  logic [CW-1:0]                    len_eff;
  logic [CW-1:0]                    len_m1;
  logic [CW-1:0]                    fill_app;
  logic [CW-1:0]                    fill_m1;
  logic [CW-1:0]                    cov;
  logic [CW-1:0]                    cov_dec;
  logic [CW-1:0]                    rem_val;
  logic                             occ;
  logic                             rel_now;
  logic [7:0]                       rel_byte;
  logic [7:0]                       flush_byte;
  logic [7:0]                       step_byte;
  logic                             step_occ;
  logic                             need_delim;
  logic                             space;
  logic                             in_acc;
  logic                             fire;
  logic                             end_chk;
  logic                             finish;
  logic                             clear_text;
  logic                             push;
  logic                             step_act;
  pod_pkg::out_item_t               push_item;

  // register port
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign cfg_idx    = paddr[pod_pkg::CFG_ADDR_W-1:pod_pkg::REG_SHIFT];
  assign cfg_len_wr = cfg_wr && (cfg_idx == pod_pkg::REG_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_raw_r  <= pod_pkg::LEN_W'(1);
      pat_low_r  <= '0;
      pat_high_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        pod_pkg::REG_LEN:  len_raw_r  <= pwdata[pod_pkg::LEN_W-1:0];
        pod_pkg::REG_LOW:  pat_low_r  <= pwdata;
        pod_pkg::REG_HIGH: pat_high_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      pod_pkg::REG_LEN:  prdata = pod_pkg::CFG_DATA_W'(len_raw_r);
      pod_pkg::REG_LOW:  prdata = pat_low_r;
      pod_pkg::REG_HIGH: prdata = pat_high_r;
      default:           prdata = '0;
    endcase
  end

  // effective pattern length
  always_comb begin
    if (len_raw_r == '0) begin
      len_eff = CW'(1);
    end else if (int'(len_raw_r) > NCELL) begin
      len_eff = CW'(NCELL);
    end else begin
      len_eff = CW'(len_raw_r);
    end
  end

  assign len_m1  = len_eff - CW'(1);
  assign pat_arr = {pat_high_r, pat_low_r};

  // cell chain, newest byte in cell 0
  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    localparam logic [CW-1:0] CELL_NUM = CW'(j);
    logic [CW-1:0] pidx;

    assign pidx      = len_m1 - CELL_NUM;
    assign beyond[j] = (CELL_NUM >= len_eff);
    assign cell_pat[j] = (int'(pidx) < pod_pkg::PAT_REG_BYTES) ?
                         pat_arr[pod_pkg::PAT_SEL_W'(pidx)] : 8'h00;

    if (j == 0) begin : g_head
      assign cell_in[j] = in_item.text_byte;
    end else begin : g_link
      assign cell_in[j] = cell_q[j-1];
    end

    pod_cell u_cell (
      .clk      (clk),
      .shift_en (in_acc),
      .byte_in  (cell_in[j]),
      .pat_byte (cell_pat[j]),
      .byte_q   (cell_q[j]),
      .match    (cell_match[j])
    );
  end

  assign occ        = &(cell_match | beyond);
  assign rel_byte   = cell_in[len_m1[IW-1:0]];
  assign fill_m1    = fill_r - CW'(1);
  assign flush_byte = cell_q[fill_m1[IW-1:0]];
  assign fill_app   = (fill_r >= len_eff) ? len_eff : fill_r + CW'(1);
  assign rel_now    = (fill_app == len_eff);

  // handshake
  assign in_ready = (st_r == pod_pkg::ST_TAKE) && space;
  assign in_acc   = in_valid && in_ready;
  assign fire     = (st_r == pod_pkg::ST_TAKE) ? in_acc : space;

  // one release step: a delimiter when region state flips, else the byte
  always_comb begin
    unique case (st_r)
      pod_pkg::ST_TAKE: begin
        step_byte = rel_byte;
        step_occ  = occ;
        rem_val   = rel_now ? len_m1 : fill_app;
      end
      pod_pkg::ST_BYTE: begin
        step_byte = held_byte_r;
        step_occ  = 1'b0;
        rem_val   = fill_r;
      end
      pod_pkg::ST_FLUSH: begin
        step_byte = flush_byte;
        step_occ  = 1'b0;
        rem_val   = fill_m1;
      end
      default: begin
        step_byte = held_byte_r;
        step_occ  = 1'b0;
        rem_val   = '0;
      end
    endcase
  end

  assign cov        = step_occ ? len_eff : cover_r;
  assign cov_dec    = (cov == '0) ? '0 : cov - CW'(1);
  assign need_delim = ((cov != '0) != inside_r);

  always_comb begin
    unique case (st_r)
      pod_pkg::ST_TAKE:  end_chk = fire && in_item.end_of_text && !(rel_now && need_delim);
      pod_pkg::ST_BYTE:  end_chk = fire && held_last_r;
      pod_pkg::ST_FLUSH: end_chk = fire && !need_delim;
      default:           end_chk = 1'b0;
    endcase
  end

  assign finish     = end_chk && (rem_val == '0) && !inside_r;
  assign clear_text = finish || (fire && (st_r == pod_pkg::ST_CLOSE)) || cfg_len_wr;
  assign end_state  = (rem_val != '0) ? pod_pkg::ST_FLUSH :
                      inside_r        ? pod_pkg::ST_CLOSE : pod_pkg::ST_TAKE;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      pod_pkg::ST_TAKE: begin
        if (fire && rel_now && need_delim) begin
          st_nxt = pod_pkg::ST_BYTE;
        end else if (end_chk) begin
          st_nxt = end_state;
        end
      end
      pod_pkg::ST_BYTE: begin
        if (fire) begin
          st_nxt = end_chk ? end_state : pod_pkg::ST_TAKE;
        end
      end
      pod_pkg::ST_FLUSH: begin
        if (end_chk) begin
          st_nxt = end_state;
        end
      end
      pod_pkg::ST_CLOSE: begin
        if (fire) begin
          st_nxt = pod_pkg::ST_TAKE;
        end
      end
      default: st_nxt = pod_pkg::ST_TAKE;
    endcase
    if (cfg_len_wr) begin
      st_nxt = pod_pkg::ST_TAKE;
    end
  end

  // outputs and text state
  assign push     = fire && ((st_r != pod_pkg::ST_TAKE) || rel_now);
  assign step_act = push && (st_r != pod_pkg::ST_CLOSE);

  always_comb begin
    push_item.out_byte = ((st_r == pod_pkg::ST_CLOSE) || need_delim) ?
                         pod_pkg::DELIM_BYTE : step_byte;
    push_item.out_last = (st_r == pod_pkg::ST_CLOSE) || finish;
  end

  always_comb begin
    fill_nxt      = fill_r;
    cover_nxt     = cover_r;
    inside_nxt    = inside_r;
    held_byte_nxt = held_byte_r;
    held_last_nxt = held_last_r;
    if (in_acc) begin
      fill_nxt      = rel_now ? len_m1 : fill_app;
      held_byte_nxt = rel_byte;
      held_last_nxt = in_item.end_of_text;
    end
    if (step_act) begin
      if (need_delim) begin
        inside_nxt = !inside_r;
        cover_nxt  = cov;
      end else begin
        cover_nxt = cov_dec;
        if (st_r == pod_pkg::ST_FLUSH) begin
          fill_nxt = fill_m1;
        end
      end
    end
    if (clear_text) begin
      fill_nxt   = '0;
      cover_nxt  = '0;
      inside_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    held_byte_r <= held_byte_nxt;
    held_last_r <= held_last_nxt;
    if (!rst_n) begin
      st_r     <= pod_pkg::ST_TAKE;
      fill_r   <= '0;
      cover_r  <= '0;
      inside_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      fill_r   <= fill_nxt;
      cover_r  <= cover_nxt;
      inside_r <= inside_nxt;
    end
  end

  pod_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push),
    .push_item  (push_item),
    .can_push   (space),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

@@ hw/rtl/pod_checker.sv @@
// port-level checks of the pattern delimiter and their binding to the top level
`include "assert_macros.svh"

module pod_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  pod_pkg::out_item_t             out_item,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [pod_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pod_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic [pod_pkg::CFG_DATA_W-1:0] prdata
);

  logic [pod_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_low;
  logic                          wr_len;

  assign reg_idx = paddr[pod_pkg::CFG_ADDR_W-1:pod_pkg::REG_SHIFT];
  assign wr_low  = rst_n && psel && penable && pwrite && pready && (reg_idx == pod_pkg::REG_LOW);
  assign wr_len  = rst_n && psel && penable && pwrite && pready && (reg_idx == pod_pkg::REG_LEN);

  // reset empties the result queue
  `ASSERT_AT(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

  // a stalled result keeps its payload
  `ASSERT_AT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_item), "stalled result changed")

  // low pattern bytes read back what was written
  `ASSERT_AT(a_low_readback, clk, wr_low |=> reg_idx != pod_pkg::REG_LOW || prdata == $past(pwdata), "pattern readback mismatch")

  // length reads back its low bits
  `ASSERT_AT(a_len_readback, clk, wr_len |=> reg_idx != pod_pkg::REG_LEN || prdata[pod_pkg::LEN_W-1:0] == $past(pwdata[pod_pkg::LEN_W-1:0]), "length readback mismatch")

endmodule

bind pattern_occurrence_delimiter pod_checker u_pod_checker (.*);

@@ tb/tb_top.sv @@
// testbench for the pattern delimiter: directed and random texts checked against a byte predictor
module tb_top;
  import pod_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_UNUSED = REG_IDX_W'(3);
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 12;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  pattern_occurrence_delimiter DUT (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [4:0] len_reg = 5'd1;
  logic [127:0] pat_bytes = '0;
  logic [7:0] held [PATTERN_MAX];
  int held_cnt = 0;
  int cover_cnt = 0;
  bit in_region = 1'b0;
  out_item_t results_due[$];

  in_item_t pending_bytes[$];
  int items_queued = 0;
  int items_taken = 0;
  int err_count = 0;
  bit sender_gaps = 1'b1;
  bit receiver_stalls = 1'b1;
  int gap_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  out_item_t due_item;
  logic [7:0] sym_a = 8'h61;
  logic [7:0] sym_b = 8'h62;

  function automatic int eff_length(logic [4:0] l);
    if (l == 0) return 1;
    if (l > PATTERN_MAX) return PATTERN_MAX;
    return int'(l);
  endfunction

  function automatic int idle_len();
    int r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void emit(logic [7:0] b);
    results_due.insert(results_due.size(), out_item_t'({b, 1'b0}));
  endfunction

  function automatic void shift_out_oldest(bit starts_match, int n);
    logic [7:0] b;
    b = held[0];
    if (starts_match) cover_cnt = n;
    if (cover_cnt > 0 && !in_region) begin
      emit(DELIM_BYTE);
      in_region = 1'b1;
    end else if (cover_cnt == 0 && in_region) begin
      emit(DELIM_BYTE);
      in_region = 1'b0;
    end
    emit(b);
    if (cover_cnt > 0) cover_cnt--;
    for (int i = 0; i + 1 < held_cnt; i++) held[i] = held[i + 1];
    if (held_cnt > 0) held_cnt--;
  endfunction

  function automatic void predict_request(in_item_t req);
    int n;
    int base;
    bit hit;
    n = eff_length(len_reg);
    base = results_due.size();
    held[held_cnt] = req.text_byte;
    held_cnt++;
    if (held_cnt == n) begin
      hit = 1'b1;
      for (int k = 0; k < n; k++) if (held[k] != pat_bytes[8*k +: 8]) hit = 1'b0;
      shift_out_oldest(hit, n);
    end
    if (req.end_of_text) begin
      while (held_cnt > 0) shift_out_oldest(1'b0, n);
      if (in_region) emit(DELIM_BYTE);
      if (results_due.size() > base) results_due[results_due.size() - 1].out_last = 1'b1;
      held_cnt = 0;
      cover_cnt = 0;
      in_region = 1'b0;
    end
  endfunction

  task automatic cfg_write(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(idx) << REG_SHIFT;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LEN: begin
        len_reg = val[4:0];
        held_cnt = 0;
        cover_cnt = 0;
        in_region = 1'b0;
      end
      REG_LOW: pat_bytes[63:0] = val;
      REG_HIGH: pat_bytes[127:64] = val;
      default: ;
    endcase
  endtask

  task automatic set_pattern(string s);
    logic [127:0] v = '0;
    for (int i = 0; i < s.len(); i++) v[8*i +: 8] = s[i];
    cfg_write(REG_LEN, CFG_DATA_W'(s.len()));
    cfg_write(REG_LOW, v[63:0]);
    cfg_write(REG_HIGH, v[127:64]);
  endtask

  task automatic queue_byte(logic [7:0] b, bit last);
    pending_bytes.insert(pending_bytes.size(), in_item_t'({b, last}));
    items_queued++;
  endtask

  task automatic queue_string(string s, bit close);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], close && i == s.len() - 1);
  endtask

  // wait until every request is taken and every result has come, then let the block drain
  task automatic settle();
    do @(posedge clk); while (items_taken != items_queued || results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_config();
    int r;
    int n;
    logic [127:0] v;
    logic [CFG_DATA_W-1:0] lw;
    r = $urandom_range(0, 99);
    if (r < 4) n = 0;
    else if (r < 9) n = $urandom_range(17, 31);
    else if (r < 14) n = 16;
    else if (r < 75) n = $urandom_range(1, 4);
    else n = $urandom_range(5, 15);
    if ($urandom_range(0, 9) < 3) n = len_reg;
    sym_a = 8'($urandom);
    sym_b = ($urandom_range(0, 3) == 0) ? 8'($urandom) : sym_a ^ 8'(1 << $urandom_range(0, 7));
    v = {$urandom, $urandom, $urandom, $urandom};
    for (int k = 0; k < eff_length(5'(n)); k++) v[8*k +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
    if (n != len_reg || $urandom_range(0, 1) == 0) begin
      lw = {$urandom, $urandom};
      lw[4:0] = 5'(n);
      cfg_write(REG_LEN, lw);
    end
    cfg_write(REG_LOW, v[63:0]);
    if (eff_length(5'(n)) > 8 || $urandom_range(0, 1) == 0) cfg_write(REG_HIGH, v[127:64]);
    if ($urandom_range(0, 19) == 0) cfg_write(REG_UNUSED, {$urandom, $urandom});
  endtask

  task automatic queue_random_text(bit close);
    int n;
    int target;
    int pick;
    int cut;
    logic [7:0] txt[$];
    n = eff_length(len_reg);
    if ($urandom_range(0, 9) == 0) target = $urandom_range(40, 90);
    else target = $urandom_range(1, 2 * n + 6);
    while (txt.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        for (int k = 0; k < n; k++) txt.insert(txt.size(), pat_bytes[8*k +: 8]);
      end else if (pick < 55) begin
        cut = $urandom_range(1, n);
        for (int k = 0; k < cut; k++) txt.insert(txt.size(), pat_bytes[8*k +: 8]);
      end else if (pick < 88) begin
        txt.insert(txt.size(), $urandom_range(0, 1) ? sym_a : sym_b);
      end else begin
        txt.insert(txt.size(), 8'($urandom));
      end
    end
    foreach (txt[i]) queue_byte(txt[i], close && i == txt.size() - 1);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_request(in_item);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_bytes.size() > 0) begin
          in_item <= pending_bytes.pop_front();
          in_valid <= 1'b1;
          gap_left <= sender_gaps ? idle_len() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("unexpected result: out_byte %h out_last %b", out_item.out_byte,
                 out_item.out_last);
          err_count++;
        end else begin
          due_item = results_due.pop_front();
          if (out_item.out_byte !== due_item.out_byte) begin
            $error("out_byte mismatch: expected %h, actual %h", due_item.out_byte,
                   out_item.out_byte);
            err_count++;
          end
          if (out_item.out_last !== due_item.out_last) begin
            $error("out_last mismatch: expected %b, actual %b", due_item.out_last,
                   out_item.out_last);
            err_count++;
          end
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready <= 1'b1;
        if (receiver_stalls && $urandom_range(0, 3) == 0) stall_left <= idle_len();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int rand_goal;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // zero length acts as one; pattern is a single zero byte
    cfg_write(REG_LEN, '0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);
    settle();

    // overlapping and touching occurrences merge, region closed at end of text
    set_pattern("aba");
    queue_string("ababaaba", 1'b1);
    settle();

    // oversized length clamps to the full window, whole text is one match
    cfg_write(REG_LEN, CFG_DATA_W'(31));
    cfg_write(REG_LOW, 64'hFF00_FF5F_0080_7F01);
    cfg_write(REG_HIGH, 64'h00FF_FE5F_5F01_80AA);
    for (int k = 0; k < PATTERN_MAX; k++) queue_byte(pat_bytes[8*k +: 8], k == PATTERN_MAX - 1);
    settle();

    // pattern bytes changed mid-text
    set_pattern("xy");
    queue_string("zx", 1'b0);
    settle();
    cfg_write(REG_LOW, 64'h7178);
    queue_string("q", 1'b1);
    settle();

    // length written mid-text drops the held bytes
    queue_string("xx", 1'b0);
    settle();
    cfg_write(REG_LEN, CFG_DATA_W'(2));
    queue_string("q", 1'b1);
    settle();

    cfg_write(REG_UNUSED, '1);
    queue_byte(DELIM_BYTE, 1'b1);
    settle();

    rand_goal = 370;
    while (items_queued < rand_goal) begin
      random_config();
      sender_gaps = $urandom_range(0, 3) != 0;
      receiver_stalls = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(1, 3)) queue_random_text(1'b1);
      if ($urandom_range(0, 2) == 0) queue_random_text(1'b0);
      settle();
    end

    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
